// File: rtl/core/odsfw_pkg.sv
// Shared types, command codes and frame constants for the octal DAC SPI frame writer.
package odsfw_pkg;

  // Default build parameters.
  localparam int CHANNELS_DEF    = 8;
  localparam int FRAME_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Frame word as built by the front end, before alignment to FRAME_BITS.
  localparam int FRAME_WORD = 32;

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int CHAN_W  = 4;
  localparam int VALUE_W = 32;
  localparam int CODE_W  = 16;
  localparam int PC_W    = 8;
  localparam int FEAT_W  = 4;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_PREFIX_CONTROL = 1'b0;
  localparam logic REG_FEATURE_BITS   = 1'b1;
  localparam logic [PC_W-1:0]   PREFIX_CONTROL_RST = 8'h03;
  localparam logic [FEAT_W-1:0] FEATURE_BITS_RST   = 4'h0;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE_CODE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_VOLT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESET      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POWER_UP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INT_REF    = 3'd4;

  // Fixed frames.
  localparam logic [FRAME_WORD-1:0] FRAME_RESET    = 32'h0700_0000;
  localparam logic [FRAME_WORD-1:0] FRAME_POWER_UP = 32'h0400_00FF;
  localparam logic [FRAME_WORD-1:0] FRAME_INT_REF  = 32'h0800_0001;

  // Code conversion constants.
  localparam logic [CODE_W-1:0]         CODE_MAX        = 16'hFFFF;
  localparam logic signed [VALUE_W-1:0] CODE_MAX_S      = 32'sd65535;
  localparam logic signed [VALUE_W-1:0] Q16_FIVE_VOLTS  = 32'sd327680;

  // Voltage path: y = (v * 131070 + 327680) >> 16, code = floor(y / 10).
  localparam int VOLT_W   = 19;   // v < 327680
  localparam int PROD_W   = 36;   // v * 131070 + 327680
  localparam int Y_W      = 20;   // y < 655360
  localparam int RECIP_W  = 20;
  localparam logic [RECIP_W-1:0] RECIP_DIV10 = 20'd838860;  // floor(2^23 / 10)
  localparam int RECIP_SHIFT = 23;

  typedef struct packed {
    logic [PC_W-1:0]   prefix_control;
    logic [FEAT_W-1:0] feature_bits;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [FRAME_WORD-1:0] frame;
  } frame_req_t;

endpackage

// File: rtl/core/odsfw_front.sv
// Front end: accepts requests, drops invalid ones, converts codes and builds frames.
module odsfw_front
  import odsfw_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CMD_W-1:0]          command_i,
  input  logic [CHAN_W-1:0]         channel_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output frame_req_t                push_o,
  input  logic                      push_ready_i
);

  localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W+1)'(CHANNELS);
  localparam logic [PROD_W-1:0] VOLT_OFFSET = PROD_W'(327680);

  // Stage 1 registers.
  logic                v1_q, v1_d;
  logic [CMD_W-1:0]    cmd1_q;
  logic [CHAN_W-1:0]   chan1_q;
  logic [CODE_W-1:0]   code1_q, code1_d;
  logic [Y_W-1:0]      y1_q;
  logic                div1_q, div1_d;

  // Stage 2 registers.
  logic                v2_q, v2_d;
  logic [CMD_W-1:0]    cmd2_q;
  logic [CHAN_W-1:0]   chan2_q;
  logic [CODE_W-1:0]   code2_q;
  logic [Y_W-1:0]      y2_q;
  logic [CODE_W-1:0]   q0_2_q;
  logic                div2_q;

  logic ready1, ready2, accept, keep, chan_ok, is_chan_cmd, is_fixed;
  logic val_pos, volt_sat;
  logic [VOLT_W-1:0]          vv;
  logic [PROD_W-1:0]          x;
  logic [Y_W+RECIP_W-1:0]     prod;
  logic [Y_W-1:0]             ten_q, rem;
  logic [CODE_W-1:0]          code_div, code_fin;
  logic [FRAME_WORD-1:0]      frame;

  assign ready2     = !v2_q || push_ready_i;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_chan_cmd = (command_i == CMD_WRITE_CODE) || (command_i == CMD_WRITE_VOLT);
  assign is_fixed    = (command_i == CMD_RESET) || (command_i == CMD_POWER_UP) ||
                       (command_i == CMD_INT_REF);
  assign chan_ok     = {1'b0, channel_i} < CHAN_LIMIT;
  assign keep        = is_fixed || (is_chan_cmd && chan_ok);

  // Classification of the value for both channel write commands.
  assign val_pos  = value_i > 32'sd0;
  assign volt_sat = value_i >= Q16_FIVE_VOLTS;
  assign vv       = value_i[VOLT_W-1:0];
  assign x = ({{(PROD_W-VOLT_W){1'b0}}, vv} << 17) -
             ({{(PROD_W-VOLT_W){1'b0}}, vv} << 1) + VOLT_OFFSET;

  always_comb begin
    div1_d  = 1'b0;
    code1_d = '0;
    if (command_i == CMD_WRITE_CODE) begin
      if (value_i >= CODE_MAX_S) begin
        code1_d = CODE_MAX;
      end else if (val_pos) begin
        code1_d = value_i[CODE_W-1:0];
      end
    end else begin
      if (val_pos && volt_sat) begin
        code1_d = CODE_MAX;
      end
      div1_d = val_pos && !volt_sat;
    end
  end

  assign v1_d = ready1 ? (accept && keep) : v1_q;
  assign v2_d = ready2 ? v1_q : v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  // Reciprocal multiply for the divide by ten.
  assign prod = y1_q * RECIP_DIV10;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd1_q  <= command_i;
      chan1_q <= channel_i;
      code1_q <= code1_d;
      y1_q    <= x[PROD_W-1:PROD_W-Y_W];
      div1_q  <= div1_d;
    end
    if (v1_q && ready2) begin
      cmd2_q  <= cmd1_q;
      chan2_q <= chan1_q;
      code2_q <= code1_q;
      y2_q    <= y1_q;
      q0_2_q  <= prod[RECIP_SHIFT+CODE_W-1:RECIP_SHIFT];
      div2_q  <= div1_q;
    end
  end

  // The reciprocal quotient is low by at most one; one compare fixes it.
  assign ten_q    = ({{(Y_W-CODE_W){1'b0}}, q0_2_q} << 3) +
                    ({{(Y_W-CODE_W){1'b0}}, q0_2_q} << 1);
  assign rem      = y2_q - ten_q;
  assign code_div = (rem >= Y_W'(10)) ? (q0_2_q + CODE_W'(1)) : q0_2_q;
  assign code_fin = div2_q ? code_div : code2_q;

  always_comb begin
    case (cmd2_q)
      CMD_WRITE_CODE, CMD_WRITE_VOLT: begin
        frame = {cfg_i.prefix_control, chan2_q, code_fin, cfg_i.feature_bits};
      end
      CMD_RESET:    frame = FRAME_RESET;
      CMD_POWER_UP: frame = FRAME_POWER_UP;
      CMD_INT_REF:  frame = FRAME_INT_REF;
      default:      frame = '0;
    endcase
  end

  assign push_o.valid = v2_q;
  assign push_o.frame = frame;

`ifndef SYNTHESIS
  a_div_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && div2_q) |-> (rem < Y_W'(20)))
    else $error("divide by ten correction out of range");
`endif

endmodule

// File: rtl/core/odsfw_queue.sv
// Short frame queue between the front end and the serializer.
module odsfw_queue
  import odsfw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  frame_req_t            push_i,
  output logic                  push_ready_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output logic [FRAME_WORD-1:0] frame_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [FRAME_WORD-1:0] entries_q [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  push_fire, pop_fire;

  assign push_ready_o = count_q != FULL_CNT;
  assign valid_o      = count_q != '0;
  assign frame_o      = entries_q[rd_ptr_q];
  assign push_fire    = push_i.valid && push_ready_o;
  assign pop_fire     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      entries_q[wr_ptr_q] <= push_i.frame;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue count above depth");
`endif

endmodule

// File: rtl/core/odsfw_back.sv
// Serializer: shifts frames out one bit per item, most significant bit first.
module odsfw_back
  import odsfw_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [FRAME_WORD-1:0] q_frame_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  data_bit_o,
  output logic                  last_bit_o
);

  localparam int CNT_W = $clog2(FRAME_BITS);
  localparam int ALIGN = FRAME_WORD - FRAME_BITS;
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(FRAME_BITS - 1);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [FRAME_WORD-1:0] shift_q, shift_d;
  logic                  take, need_load;

  assign out_valid_o = busy_q;
  assign data_bit_o  = shift_q[FRAME_WORD-1];
  assign last_bit_o  = cnt_q == '0;

  assign take      = busy_q && !out_stall_i;
  assign need_load = !busy_q || (take && (cnt_q == '0));
  assign q_pop_o   = need_load && q_valid_i;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    if (q_pop_o) begin
      busy_d  = 1'b1;
      cnt_d   = CNT_LOAD;
      shift_d = q_frame_i << ALIGN;
    end else if (need_load) begin
      busy_d = 1'b0;
    end else if (take) begin
      cnt_d   = cnt_q - CNT_W'(1);
      shift_d = shift_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

`ifndef SYNTHESIS
  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_stall_i && (cnt_q != '0)) |=> busy_q)
    else $error("frame ended before its last bit");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= CNT_LOAD))
    else $error("bit counter above frame length");
`endif

endmodule

// File: rtl/core/octal_dac_spi_frame_writer_core.sv
// Top level of the octal DAC SPI frame writer: configuration registers and block wiring.
//
// Each accepted request item is turned into one serial DAC frame that leaves on the output
// channel as FRAME_BITS items (32 by default), one data bit per item, most significant bit
// first, with last_bit_o set on the final bit. Channel writes (code or voltage) form the frame
// from prefix_control, the channel number, the 16-bit code and feature_bits; the reset,
// power-up-all and internal-reference commands send fixed frames. A channel write to a channel
// at or above CHANNELS, or an unknown command, is accepted but produces no items.
// The serializer sends one bit per clock while the output is not stalled, and frames follow
// one another without a gap while the queue holds the next one; that one bit per clock shift
// register is what limits the sustained request rate. The front end registers a request in
// stage 1, the reciprocal multiply for the voltage divide in stage 2, then corrects and
// assembles the frame on the way into the queue, and keeps taking requests while the
// serializer is busy until its QUEUE_DEPTH-entry frame queue and its two stages are full.
// prefix_control (address 0, reset 0x03) and feature_bits (address 4, reset 0x0) are written
// through the APB port and should only change while no frame is in flight.
module octal_dac_spi_frame_writer_core
  import odsfw_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int FRAME_BITS  = FRAME_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]     pwdata,
  output logic [APB_DATA_W-1:0]     prdata,
  output logic                      pready,
  // Request items.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CMD_W-1:0]          command_i,
  input  logic [CHAN_W-1:0]         channel_i,
  input  logic signed [VALUE_W-1:0] value_i,
  // Frame bit items.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      data_bit_o,
  output logic                      last_bit_o
);

  cfg_t                  cfg_q, cfg_d;
  logic                  cfg_write;
  logic                  reg_idx;
  frame_req_t            push;
  logic                  push_ready;
  logic                  q_valid, q_pop;
  logic [FRAME_WORD-1:0] q_frame;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_idx)
        REG_PREFIX_CONTROL: cfg_d.prefix_control = pwdata[PC_W-1:0];
        REG_FEATURE_BITS:   cfg_d.feature_bits   = pwdata[FEAT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prefix_control <= PREFIX_CONTROL_RST;
      cfg_q.feature_bits   <= FEATURE_BITS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Reads return the register value, zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_PREFIX_CONTROL: prdata = {{(APB_DATA_W-PC_W){1'b0}}, cfg_q.prefix_control};
      REG_FEATURE_BITS:   prdata = {{(APB_DATA_W-FEAT_W){1'b0}}, cfg_q.feature_bits};
      default:            prdata = '0;
    endcase
  end

  // The front end classifies requests and produces complete frames.
  odsfw_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .channel_i    (channel_i),
    .value_i      (value_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  // The queue lets the front end keep accepting while a frame is being shifted.
  odsfw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .frame_o      (q_frame)
  );

  // The serializer drives the output items straight from its registers.
  odsfw_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_frame_i   (q_frame),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_bit_o  (data_bit_o),
    .last_bit_o  (last_bit_o)
  );

endmodule

// File: tb/tb_octal_dac_spi_frame_writer_core.sv
// Self-checking testbench for the octal DAC SPI frame writer core.
module tb_octal_dac_spi_frame_writer_core;
  import odsfw_pkg::*;

  localparam int TIMEOUT_TIME  = 6_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 210;
  localparam int RANDOM_PHASES = 5;

  // Register addresses and reset values as the register map defines them.
  localparam logic [APB_ADDR_W-1:0] ADDR_PREFIX_CONTROL =
      APB_ADDR_W'(int'(REG_PREFIX_CONTROL) * 4);
  localparam logic [APB_ADDR_W-1:0] ADDR_FEATURE_BITS =
      APB_ADDR_W'(int'(REG_FEATURE_BITS) * 4);
  localparam logic [PC_W-1:0]   PREFIX_RESET_VAL  = 8'h03;
  localparam logic [FEAT_W-1:0] FEATURE_RESET_VAL = 4'h0;

  // Fixed frames and conversion constants of the DAC command set.
  localparam logic [FRAME_WORD-1:0] DAC_RESET_WORD    = 32'h0700_0000;
  localparam logic [FRAME_WORD-1:0] DAC_POWER_UP_WORD = 32'h0400_00FF;
  localparam logic [FRAME_WORD-1:0] DAC_INT_REF_WORD  = 32'h0800_0001;
  localparam logic [CODE_W-1:0]     FULL_SCALE_CODE   = 16'hFFFF;
  localparam int                    FULL_SCALE_INT    = 65535;
  localparam int                    FIVE_VOLTS_Q16    = 327680;
  localparam longint                VOLT_SCALE_NUM    = 131070;
  localparam longint                VOLT_SCALE_DEN    = 655360;
  localparam longint                VOLT_ROUND_BIAS   = 327680;

  typedef struct packed {
    logic data_bit;
    logic last_bit;
  } serial_bit_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0]     pwdata;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [CMD_W-1:0]          command_i;
  logic [CHAN_W-1:0]         channel_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic                      data_bit_o;
  logic                      last_bit_o;

  // Predictor state: register copy, shadow code table and pending frame bits.
  cfg_t              dac_cfg;
  logic [CODE_W-1:0] shadow_code [CHANNELS_DEF];
  serial_bit_t       pending_bits [$];

  int  failures;
  int  requests_sent;
  int  requests_ignored;
  int  frames_predicted;
  int  bits_checked;
  int  settings_applied;
  int  burst_left;
  bit  sender_gaps_on;
  bit  stall_pattern_on;
  bit  hold_request;

  octal_dac_spi_frame_writer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .channel_i   (channel_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_bit_o  (data_bit_o),
    .last_bit_o  (last_bit_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(TIMEOUT_TIME);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame prediction
  // ---------------------------------------------------------------------------

  function automatic logic [CODE_W-1:0] code_from_value(input logic signed [VALUE_W-1:0] v);
    if (v <= 0) return '0;
    if (v >= FULL_SCALE_INT) return FULL_SCALE_CODE;
    return v[CODE_W-1:0];
  endfunction

  // Rounds v * 65535 / 5 (v in volts, Q16) to nearest, ties up, in exact integers.
  function automatic logic [CODE_W-1:0] code_from_volts(input logic signed [VALUE_W-1:0] v);
    longint scaled;
    if (v <= 0) return '0;
    if (v >= FIVE_VOLTS_Q16) return FULL_SCALE_CODE;
    scaled = longint'(v) * VOLT_SCALE_NUM + VOLT_ROUND_BIAS;
    return CODE_W'(scaled / VOLT_SCALE_DEN);
  endfunction

  function automatic void predict_request(input logic [CMD_W-1:0] cmd,
                                          input logic [CHAN_W-1:0] chan,
                                          input logic signed [VALUE_W-1:0] value);
    logic [FRAME_WORD-1:0] frame;
    logic [FRAME_WORD-1:0] aligned;
    logic [CODE_W-1:0]     code;
    bit                    sends;
    sends = 1'b1;
    frame = '0;
    case (cmd)
      CMD_WRITE_CODE, CMD_WRITE_VOLT: begin
        if (int'(chan) >= CHANNELS_DEF) begin
          sends = 1'b0;
        end else begin
          code = (cmd == CMD_WRITE_CODE) ? code_from_value(value) : code_from_volts(value);
          shadow_code[chan] = code;
          frame = {dac_cfg.prefix_control, chan, code, dac_cfg.feature_bits};
        end
      end
      CMD_RESET:    frame = DAC_RESET_WORD;
      CMD_POWER_UP: frame = DAC_POWER_UP_WORD;
      CMD_INT_REF:  frame = DAC_INT_REF_WORD;
      default:      sends = 1'b0;
    endcase
    if (!sends) begin
      requests_ignored++;
      return;
    end
    aligned = frame << (FRAME_WORD - FRAME_BITS_DEF);
    for (int k = 0; k < FRAME_BITS_DEF; k++) begin
      pending_bits.push_back('{data_bit: aligned[FRAME_WORD-1-k],
                               last_bit: (k == FRAME_BITS_DEF - 1)});
    end
    frames_predicted++;
  endfunction

  // Every accepted bit is compared against the oldest pending one.
  always @(posedge clk_i) begin
    serial_bit_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bits.size() == 0) begin
        $error("Frame bit arrived with nothing pending: data_bit %0b last_bit %0b",
               data_bit_o, last_bit_o);
        failures++;
      end else begin
        want = pending_bits.pop_front();
        bits_checked++;
        if (data_bit_o !== want.data_bit) begin
          $error("data_bit mismatch: expected %0b, got %0b", want.data_bit, data_bit_o);
          failures++;
        end
        if (last_bit_o !== want.last_bit) begin
          $error("last_bit mismatch: expected %0b, got %0b", want.last_bit, last_bit_o);
          failures++;
        end
      end
    end
  end

  // Receiver: free-running stall pattern, no stalls while it is off, or one long hold when asked for.
  initial begin : receiver
    int  run_left;
    int  held;
    bit  run_stalled;
    run_left = 0;
    run_stalled = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < LONG_HOLD; held++) @(negedge clk_i);
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!stall_pattern_on) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stalled = ($urandom_range(0, 2) == 0);
          run_left = run_stalled ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end
        out_stall_i <= run_stalled;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------------

  task automatic apb_transfer(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_registers();
    logic [APB_DATA_W-1:0] rdata;
    apb_transfer(1'b0, ADDR_PREFIX_CONTROL, '0, rdata);
    if (rdata !== APB_DATA_W'(dac_cfg.prefix_control)) begin
      $error("prefix_control readback mismatch: expected %0h, got %0h",
             dac_cfg.prefix_control, rdata);
      failures++;
    end
    apb_transfer(1'b0, ADDR_FEATURE_BITS, '0, rdata);
    if (rdata !== APB_DATA_W'(dac_cfg.feature_bits)) begin
      $error("feature_bits readback mismatch: expected %0h, got %0h",
             dac_cfg.feature_bits, rdata);
      failures++;
    end
  endtask

  // Only called while no frame is in flight.
  task automatic apply_config(input logic [PC_W-1:0] prefix, input logic [FEAT_W-1:0] feat);
    logic [APB_DATA_W-1:0] unused;
    apb_transfer(1'b1, ADDR_PREFIX_CONTROL, APB_DATA_W'(prefix), unused);
    dac_cfg.prefix_control = prefix;
    apb_transfer(1'b1, ADDR_FEATURE_BITS, APB_DATA_W'(feat), unused);
    dac_cfg.feature_bits = feat;
    settings_applied++;
    check_registers();
  endtask

  // Offers one request item, waits for it to be taken, and may open a gap after it.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] chan,
                              input logic signed [VALUE_W-1:0] value);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    channel_i  <= chan;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
    predict_request(cmd, chan, value);
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        burst_left = $urandom_range(0, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stops offering, waits for every pending bit, then covers the front-end latency.
  task automatic drain_frames();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    logic [CMD_W-1:0]          cmd;
    logic [CHAN_W-1:0]         chan;
    logic signed [VALUE_W-1:0] value;
    int                        pick;
    pick  = $urandom_range(0, 99);
    chan  = CHAN_W'($urandom_range(0, CHANNELS_DEF - 1));
    value = $urandom;
    if (pick < 35) begin
      cmd = CMD_WRITE_CODE;
      case ($urandom_range(0, 3))
        0: value = $urandom_range(0, 70000);
        1: value = FULL_SCALE_INT + $urandom_range(0, 4) - 2;
        2: value = -$urandom_range(0, 1000);
        default: ;
      endcase
    end else if (pick < 70) begin
      cmd = CMD_WRITE_VOLT;
      case ($urandom_range(0, 3))
        0, 1: value = $urandom_range(0, FIVE_VOLTS_Q16 + 5000);
        2: value = FIVE_VOLTS_Q16 + $urandom_range(0, 4) - 2;
        default: ;
      endcase
    end else if (pick < 78) begin
      cmd  = CMD_W'($urandom_range(CMD_RESET, CMD_INT_REF));
      chan = CHAN_W'($urandom);
    end else if (pick < 90) begin
      cmd  = ($urandom_range(0, 1) == 0) ? CMD_WRITE_CODE : CMD_WRITE_VOLT;
      chan = CHAN_W'($urandom_range(CHANNELS_DEF, (1 << CHAN_W) - 1));
    end else begin
      cmd  = CMD_W'($urandom_range(CMD_INT_REF + 1, (1 << CMD_W) - 1));
      chan = CHAN_W'($urandom);
    end
    send_request(cmd, chan, value);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_reset();
    check_registers();
  endtask

  // Fixed frames must not depend on channel or value.
  task automatic test_fixed_frames();
    send_request(CMD_RESET, 4'hF, 32'sh7FFF_FFFF);
    send_request(CMD_POWER_UP, 4'h0, -32'sd1);
    send_request(CMD_INT_REF, 4'h9, 32'sh0000_1234);
    drain_frames();
  endtask

  task automatic test_code_clamp();
    send_request(CMD_WRITE_CODE, 4'd0, 32'sh8000_0000);
    send_request(CMD_WRITE_CODE, 4'd7, 32'sh7FFF_FFFF);
    send_request(CMD_WRITE_CODE, 4'd1, -32'sd1);
    send_request(CMD_WRITE_CODE, 4'd2, 32'sd0);
    send_request(CMD_WRITE_CODE, 4'd3, 32'sd1);
    send_request(CMD_WRITE_CODE, 4'd4, 32'sd65534);
    send_request(CMD_WRITE_CODE, 4'd5, 32'sd65536);
    drain_frames();
  endtask

  // Voltage writes: both clamps, the 5 V boundary and an exact rounding tie (0.5 V).
  task automatic test_volt_scaling();
    send_request(CMD_WRITE_VOLT, 4'd0, 32'sh8000_0000);
    send_request(CMD_WRITE_VOLT, 4'd1, 32'sd0);
    send_request(CMD_WRITE_VOLT, 4'd2, 32'sd1);
    send_request(CMD_WRITE_VOLT, 4'd3, 32'sd32768);
    send_request(CMD_WRITE_VOLT, 4'd4, 32'sd327679);
    send_request(CMD_WRITE_VOLT, 4'd5, 32'sd327680);
    send_request(CMD_WRITE_VOLT, 4'd6, 32'sd327681);
    send_request(CMD_WRITE_VOLT, 4'd7, 32'sh7FFF_FFFF);
    drain_frames();
  endtask

  // Out-of-range channels and unknown commands are swallowed without a frame.
  task automatic test_ignored_requests();
    send_request(CMD_WRITE_CODE, 4'd8, 32'sd1000);
    send_request(CMD_WRITE_VOLT, 4'd15, 32'sd100000);
    for (int c = int'(CMD_INT_REF) + 1; c < (1 << CMD_W); c++) begin
      send_request(CMD_W'(c), CHAN_W'(c), -32'sd5);
    end
    send_request(CMD_WRITE_CODE, 4'd6, 32'sd43690);
    drain_frames();
  endtask

  task automatic test_config_extremes();
    apply_config(8'h00, 4'h0);
    repeat (4) send_random_request();
    drain_frames();
    apply_config(8'hFF, 4'hF);
    repeat (4) send_random_request();
    drain_frames();
    apply_config(PC_W'($urandom), FEAT_W'($urandom));
    repeat (4) send_random_request();
    drain_frames();
  endtask

  // The receiver holds off while items keep coming, so the block must fill and stall.
  task automatic test_back_pressure();
    sender_gaps_on = 1'b0;
    hold_request = 1'b1;
    for (int n = 0; n < 16; n++) begin
      send_request(CMD_WRITE_CODE, CHAN_W'(n % CHANNELS_DEF), $urandom);
    end
    drain_frames();
  endtask

  task automatic test_random_traffic();
    int goal;
    logic [PC_W-1:0]   prefix;
    logic [FEAT_W-1:0] feat;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 2))
        0: prefix = 8'h00;
        1: prefix = 8'hFF;
        default: prefix = PC_W'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0: feat = 4'h0;
        1: feat = 4'hF;
        default: feat = FEAT_W'($urandom);
      endcase
      apply_config(prefix, feat);
      // One phase runs flat out on both sides.
      sender_gaps_on   = (phase != 1);
      stall_pattern_on = (phase != 1);
      goal = requests_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (requests_sent < goal) send_random_request();
      drain_frames();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    command_i        = CMD_WRITE_CODE;
    channel_i        = '0;
    value_i          = '0;
    out_stall_i      = 1'b0;
    failures         = 0;
    requests_sent    = 0;
    requests_ignored = 0;
    frames_predicted = 0;
    bits_checked     = 0;
    settings_applied = 0;
    burst_left       = 0;
    sender_gaps_on   = 1'b1;
    stall_pattern_on = 1'b1;
    hold_request     = 1'b0;
    dac_cfg.prefix_control = PREFIX_RESET_VAL;
    dac_cfg.feature_bits   = FEATURE_RESET_VAL;
    foreach (shadow_code[i]) shadow_code[i] = '0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_fixed_frames();
    test_code_clamp();
    test_volt_scaling();
    test_ignored_requests();
    test_config_extremes();
    test_back_pressure();
    test_random_traffic();

    if (pending_bits.size() != 0) begin
      $error("%0d frame bits never arrived", pending_bits.size());
      failures++;
    end
    $display("Sent %0d request items (%0d ignored); checked %0d frames, %0d serial bits.",
             requests_sent, requests_ignored, frames_predicted, bits_checked);
    $display("Applied %0d register settings, with a long output hold-off and random idling.",
             settings_applied);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/odsfw_pkg.sv
rtl/core/odsfw_front.sv
rtl/core/odsfw_queue.sv
rtl/core/odsfw_back.sv
rtl/core/octal_dac_spi_frame_writer_core.sv
tb/tb_octal_dac_spi_frame_writer_core.sv
